/* hw/rtl/mr_pkg.sv */
// Package: shared constants and types for the Miller-Rabin primality tester.
`timescale 1ns / 1ps
`default_nettype none
package mr_pkg;
  localparam int Width = 64;
  localparam int BaseCount = 12;
  localparam int BaseIdxW = 4;
  localparam int BitIdxW = 6;

  typedef logic [Width-1:0] word_t;

  function automatic logic [5:0] base_value(input logic [BaseIdxW-1:0] idx);
    logic [5:0] v;
    case (idx)
      4'd0: v = 6'd2;
      4'd1: v = 6'd3;
      4'd2: v = 6'd5;
      4'd3: v = 6'd7;
      4'd4: v = 6'd11;
      4'd5: v = 6'd13;
      4'd6: v = 6'd17;
      4'd7: v = 6'd19;
      4'd8: v = 6'd23;
      4'd9: v = 6'd29;
      4'd10: v = 6'd31;
      4'd11: v = 6'd37;
      default: v = 6'd2;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic start;
    word_t x;
    word_t y;
  } mm_req_t;

  typedef struct packed {
    logic done;
    word_t r;
  } mm_rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/mr_mulmod.sv */
// Module: bit-serial modular multiplier, one double-and-add step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mr_mulmod
  import mr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire word_t   modulus,
  input  wire mm_req_t req,
  output mm_rsp_t      rsp
);
  word_t r;
  word_t x;
  word_t y;
  logic [BitIdxW-1:0] cnt;
  logic busy;
  word_t r_dbl;
  word_t r_next;

  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    logic [Width:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[Width-1:0];
  endfunction

  always_comb begin
    r_dbl = add_mod(r, r, modulus);
    r_next = y[Width-1] ? add_mod(r_dbl, x, modulus) : r_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        r <= '0;
        x <= req.x;
        y <= req.y;
        cnt <= '0;
      end else if (busy) begin
        r <= r_next;
        y <= y << 1;
        cnt <= cnt + BitIdxW'(1);
        if (cnt == BitIdxW'(Width - 1)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.r <= r_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !req.start)
    else $error("multiplier restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) rsp.done |-> !busy)
    else $error("done while busy");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy))
    else $error("done without work");
`endif
endmodule
`default_nettype wire

/* hw/rtl/primality_test_64bit.sv */
// Top level: deterministic 64-bit Miller-Rabin primality tester.
`timescale 1ns / 1ps
`default_nettype none
// One number arrives per s_axis word; one is_prime word leaves per input. Each
// odd n > 3 runs twelve bases (2..37). A base above n is first brought below n
// by repeated subtraction. Per base, square-and-multiply walks all 64 exponent
// bits of d, followed by up to s-1 extra squarings; every modular product
// goes through the shared bit-serial multiplier (issue, load, one double-and-add
// step per bit, hand back). Since popcount(d) + s - 1 <= 63, a base needs at
// most 64 + 63 products. Even numbers and 1, 2, 3 go straight from idle to
// the output state.
// The block takes no new word until the result word has been accepted.
module primality_test_64bit
  import mr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] number
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [0] is_prime, [7:1] zero
);
  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_BASE, S_REDUCE, S_EXP, S_MUL_R, S_SQR_X, S_CHECK, S_SQ,
    S_SQ_WAIT, S_OUT
  } state_t;

  state_t state;
  word_t n, d, e, rr, xx;
  logic [BitIdxW:0] s_cnt, j;
  logic [BaseIdxW-1:0] bidx;
  logic [BitIdxW:0] ecnt;
  logic result;
  mm_req_t req;
  mm_rsp_t rsp;
  word_t a;
  word_t nm1;

  mr_mulmod u_mm (.clk(clk), .rst(rst), .modulus(n), .req(req), .rsp(rsp));

  assign a = word_t'(base_value(bidx));
  assign nm1 = n - word_t'(1);
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {7'd0, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            n <= s_axis_tdata;
            if (s_axis_tdata == 64'd2 || s_axis_tdata == 64'd3 || s_axis_tdata == 64'd1) begin
              result <= 1'b1; state <= S_OUT;
            end else if (!s_axis_tdata[0]) begin
              result <= 1'b0; state <= S_OUT;
            end else begin
              d <= s_axis_tdata - 64'd1; s_cnt <= '0; bidx <= '0; state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          // strip factors of two from n-1, one per cycle
          if (d[0]) state <= S_BASE;
          else begin d <= d >> 1; s_cnt <= s_cnt + (BitIdxW+1)'(1); end
        end
        S_BASE: begin
          if (a == n) begin
            // bases are prime, so a base is a multiple of odd n > 1 only when equal
            if (bidx == BaseIdxW'(BaseCount - 1)) begin result <= 1'b1; state <= S_OUT; end
            else bidx <= bidx + BaseIdxW'(1);
          end else begin
            rr <= word_t'(1); e <= d; ecnt <= '0;
            xx <= a;
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // small odd n: bring the base below n by subtraction
          if (xx >= n) xx <= xx - n;
          else state <= S_EXP;
        end
        S_EXP: begin
          if (ecnt == (BitIdxW+1)'(Width)) begin
            j <= (BitIdxW+1)'(1); state <= S_CHECK;
          end else if (e[0]) begin
            req.start <= 1'b1; req.x <= rr; req.y <= xx; state <= S_MUL_R;
          end else begin
            req.start <= 1'b1; req.x <= xx; req.y <= xx; state <= S_SQR_X;
          end
        end
        S_MUL_R: if (rsp.done) begin
          rr <= rsp.r; req.start <= 1'b1; req.x <= xx; req.y <= xx; state <= S_SQR_X;
        end
        S_SQR_X: if (rsp.done) begin
          xx <= rsp.r; e <= e >> 1; ecnt <= ecnt + (BitIdxW+1)'(1); state <= S_EXP;
        end
        S_CHECK: begin
          if (rr == word_t'(1) || rr == nm1) begin
            if (bidx == BaseIdxW'(BaseCount - 1)) begin result <= 1'b1; state <= S_OUT; end
            else begin bidx <= bidx + BaseIdxW'(1); state <= S_BASE; end
          end else begin
            j <= (BitIdxW+1)'(1); state <= S_SQ;
          end
        end
        S_SQ: begin
          if (j >= s_cnt) begin result <= 1'b0; state <= S_OUT; end
          else begin req.start <= 1'b1; req.x <= rr; req.y <= rr; state <= S_SQ_WAIT; end
        end
        S_SQ_WAIT: if (rsp.done) begin
          rr <= rsp.r; j <= j + (BitIdxW+1)'(1);
          if (rsp.r == nm1) begin
            if (bidx == BaseIdxW'(BaseCount - 1)) begin result <= 1'b1; state <= S_OUT; end
            else begin bidx <= bidx + BaseIdxW'(1); state <= S_BASE; end
          end else state <= S_SQ;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
  a_even_comp: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tready && s_axis_tvalid && !s_axis_tdata[0] && s_axis_tdata != 64'd2)
    |=> (m_axis_tvalid && m_axis_tdata[0] == 1'b0)) else $error("even not composite");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for primality_test_64bit: directed and random numbers checked against a local predictor.
`timescale 1ns / 1ps
module testbench;
  import mr_pkg::*;

  // Idle/stall modes applied by each test phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  localparam int StallPct = 56;
  localparam int BothPct = 33;
  // Well above the worst case per word in the DUT plus stalls
  localparam int WatchdogLimit = 1000000;
  localparam int DrainCycles = 200;
  localparam int MaxReported = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] number
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] is_prime, [7:1] zero

  idle_mode_t idle_mode = IDLE_NONE;

  // Expected verdicts, oldest first, with the number that produced each
  logic  verdict_q[$];
  word_t number_q[$];

  int mismatches = 0;
  int quiet_cycles = 0;

  primality_test_64bit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: exact modular arithmetic through a full 128-bit product
  // ---------------------------------------------------------------------------
  function automatic word_t mod_mul(word_t x, word_t y, word_t m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return word_t'(p % {64'd0, m});
  endfunction

  function automatic word_t mod_pow(word_t b, word_t e, word_t m);
    word_t r;
    word_t x;
    r = (m == 1) ? word_t'(0) : word_t'(1);
    x = b % m;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, x, m);
      x = mod_mul(x, x, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic predict_prime(word_t n);
    word_t d;
    word_t t;
    int    s;
    logic  ok;
    logic  pass;
    int    bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    if (n == 2 || n == 3) return 1'b1;
    if (!n[0]) return 1'b0;
    if (n == 1) return 1'b1;   // every base is a multiple of one
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    ok = 1'b1;
    foreach (bases[i]) begin
      pass = 1'b0;
      if (word_t'(bases[i]) % n == 0) begin
        pass = 1'b1;            // base is a multiple of n
      end else begin
        t = mod_pow(word_t'(bases[i]), d, n);
        if (t == 1 || t == n - 1) pass = 1'b1;
        for (int j = 1; j < s && !pass; j++) begin
          t = mod_mul(t, t, n);
          if (t == n - 1) pass = 1'b1;
        end
      end
      if (!pass) ok = 1'b0;
    end
    return ok;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random tready per mode
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: m_axis_tready <= ($urandom_range(99) >= StallPct);
      IDLE_BOTH: m_axis_tready <= ($urandom_range(99) >= BothPct);
      default:   m_axis_tready <= 1'b1;
    endcase
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    logic  want;
    word_t num;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result word 0x%02h", m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        num = number_q.pop_front();
        if (m_axis_tdata !== {7'd0, want}) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("n=%0d: expected is_prime=%0b, got tdata=0x%02h", num, want,
                     m_axis_tdata);
        end
      end
    end
  end

  // Watchdog: cycles without any handshake on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("** primality_test_64bit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one number per call; valid stays high into the next call
  // ---------------------------------------------------------------------------
  task automatic send_number(word_t n);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? StallPct : (idle_mode == IDLE_BOTH) ? BothPct : 0;
    while ($urandom_range(99) < pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= n;
    do @(posedge clk); while (!s_axis_tready);
    verdict_q = {verdict_q, predict_prime(n)};
    number_q = {number_q, n};
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Random number: mostly even or tiny, the rest full-width odd
  function automatic word_t random_number();
    word_t n;
    int    pick;
    n = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 40) n[0] = 1'b0;
    else if (pick < 55) n = word_t'($urandom_range(63));
    else n[0] = 1'b1;
    return n;
  endfunction

  task automatic test_directed();
    word_t list[$] = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd37, 64'd41,
      64'd561,                       // Carmichael number
      64'd3215031751,                // strong pseudoprime to bases 2,3,5,7
      64'hFFFF_FFFF_FFFF_FFC5,       // largest 64-bit prime
      64'hFFFF_FFFF_FFFF_FFFF,       // all ones
      64'hFFFF_FFFF_FFFF_FFFE,       // largest even
      64'h8000_0000_0000_0000,
      64'd9                          // odd square
    };
    idle_mode = IDLE_NONE;
    foreach (list[i]) send_number(list[i]);
    wait_results();
  endtask

  task automatic test_random(idle_mode_t mode, int count);
    idle_mode = mode;
    for (int i = 0; i < count; i++) send_number(random_number());
    wait_results();
  endtask

  // Sender holds off until the block has drained before each word
  task automatic test_drained_sends();
    idle_mode = IDLE_BOTH;
    for (int i = 0; i < 4; i++) begin
      send_number(random_number());
      wait_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(IDLE_NONE, 24);
    test_random(IDLE_SEND, 24);
    test_random(IDLE_RECV, 24);
    test_random(IDLE_BOTH, 24);
    test_drained_sends();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("** primality_test_64bit: PASSED **");
    end else begin
      $display("** primality_test_64bit: FAILED **");
    end
    $finish;
  end
endmodule
